/* rtl/core/dufp_pkg.sv */
package dufp_pkg;

	// Largest number of channel writes taken from one data frame.
	localparam int MAX_CHANNELS = 512;
	localparam int CHAN_W = 9;
	localparam int LEN_RAW_W = $clog2(MAX_CHANNELS + 1);
	// The low length byte is parked in the same register, so it is never narrower than a byte.
	localparam int LEN_W = (LEN_RAW_W > 8) ? LEN_RAW_W : 8;

	localparam logic [7:0] BYTE_SOF  = 8'h7E;
	localparam logic [7:0] BYTE_EOF  = 8'hE7;
	localparam logic [7:0] BYTE_HDR0 = 8'h01;
	localparam logic [7:0] BYTE_HDR1 = 8'h60;

	localparam logic [7:0] LBL_PARAMS    = 8'd3;
	localparam logic [7:0] LBL_DMX_BOTH  = 8'd6;
	localparam logic [7:0] LBL_SERIAL    = 8'd10;
	localparam logic [7:0] LBL_SERIAL_B  = 8'd13;
	localparam logic [7:0] LBL_VENDOR    = 8'd77;
	localparam logic [7:0] LBL_NAME      = 8'd78;
	localparam logic [7:0] LBL_DMX_U0    = 8'd100;
	localparam logic [7:0] LBL_DMX_U1    = 8'd101;
	localparam logic [7:0] LBL_SERIAL_C  = 8'd203;

	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_LED   = 2'd2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PARAMS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SERIAL = 2'd1;

	localparam logic [39:0] PARAMS_RESET = 40'd171816059136;
	localparam logic [63:0] SERIAL_RESET = 64'd3625458551972383812;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Reply burst position: header, frame, payload of up to 15 bytes, end byte.
	localparam int RIDX_W = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LABEL,
		ST_LEN_LO,
		ST_LEN_HI,
		ST_DATA,
		ST_END
	} parse_state_t;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_LED,
		CMD_REPLY
	} cmd_op_t;

	typedef enum logic [1:0] {
		RPL_PARAMS,
		RPL_SERIAL,
		RPL_VENDOR,
		RPL_NAME
	} reply_sel_t;

	typedef struct packed {
		cmd_op_t           op;
		reply_sel_t        rsel;
		logic [7:0]        data;
		logic [1:0]        mask;
		logic [CHAN_W-1:0] chan;
	} cmd_t;

	function automatic logic [7:0] vendor_byte(input logic [3:0] i);
		logic [7:0] b;
		case (i)
			4'd0:    b = 8'h6B;
			4'd1:    b = 8'h6A;
			4'd2:    b = 8'h44;
			4'd3:    b = 8'h4D;
			4'd4:    b = 8'h58;
			4'd5:    b = 8'h4C;
			4'd6:    b = 8'h49;
			4'd7:    b = 8'h46;
			4'd8:    b = 8'h45;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] name_byte(input logic [3:0] i);
		logic [7:0] b;
		case (i)
			4'd0:    b = 8'h02;
			4'd1:    b = 8'h00;
			4'd2:    b = 8'h44;
			4'd3:    b = 8'h4D;
			4'd4:    b = 8'h58;
			4'd5:    b = 8'h20;
			4'd6:    b = 8'h55;
			4'd7:    b = 8'h6C;
			4'd8:    b = 8'h74;
			4'd9:    b = 8'h72;
			4'd10:   b = 8'h61;
			4'd11:   b = 8'h20;
			4'd12:   b = 8'h50;
			4'd13:   b = 8'h72;
			4'd14:   b = 8'h6F;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* rtl/core/dufp_front.sv */
module dufp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  logic [7:0]          rx_byte,
	output logic                cmd_push,
	output dufp_pkg::cmd_t      cmd
);

	dufp_pkg::parse_state_t state_q, state_next;
	logic [7:0]                label_q;
	logic [dufp_pkg::LEN_W-1:0] len_q, len_d;
	logic [dufp_pkg::LEN_W-1:0] woff_q, woff_n;
	logic                      scp_q;

	logic        is_data;
	logic [15:0] full_len, adj_len, clip_len;

	always_comb begin
		case (label_q) inside
			dufp_pkg::LBL_DMX_BOTH, dufp_pkg::LBL_DMX_U0, dufp_pkg::LBL_DMX_U1: is_data = 1'b1;
			default: is_data = 1'b0;
		endcase
	end

	assign full_len = {rx_byte, len_q[7:0]};
	assign adj_len  = is_data ? (full_len - 16'd1) : full_len;
	assign clip_len = (adj_len > 16'(dufp_pkg::MAX_CHANNELS)) ?
		16'(dufp_pkg::MAX_CHANNELS) : adj_len;
	assign len_d    = dufp_pkg::LEN_W'(clip_len);
	assign woff_n   = scp_q ? woff_q : (woff_q + dufp_pkg::LEN_W'(1));

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			dufp_pkg::ST_IDLE: begin
				if (rx_byte == dufp_pkg::BYTE_SOF) state_next = dufp_pkg::ST_LABEL;
			end
			dufp_pkg::ST_LABEL:  state_next = dufp_pkg::ST_LEN_LO;
			dufp_pkg::ST_LEN_LO: state_next = dufp_pkg::ST_LEN_HI;
			dufp_pkg::ST_LEN_HI: begin
				state_next = (full_len == 16'd0) ? dufp_pkg::ST_END : dufp_pkg::ST_DATA;
			end
			dufp_pkg::ST_DATA: begin
				if (woff_n >= len_q) state_next = dufp_pkg::ST_END;
			end
			dufp_pkg::ST_END: begin
				if (rx_byte == dufp_pkg::BYTE_EOF) state_next = dufp_pkg::ST_IDLE;
			end
			default: begin
				state_next = (rx_byte == dufp_pkg::BYTE_SOF) ?
					dufp_pkg::ST_LABEL : dufp_pkg::ST_IDLE;
			end
		endcase
	end

	// Command output.
	always_comb begin
		cmd_push = 1'b0;
		cmd.op   = dufp_pkg::CMD_LED;
		cmd.rsel = dufp_pkg::RPL_PARAMS;
		cmd.data = rx_byte;
		cmd.mask = 2'b00;
		cmd.chan = dufp_pkg::CHAN_W'(woff_q);
		case (state_q)
			dufp_pkg::ST_DATA: begin
				cmd_push = acc && !scp_q && is_data;
				cmd.op   = dufp_pkg::CMD_WRITE;
				case (label_q)
					dufp_pkg::LBL_DMX_BOTH: cmd.mask = 2'b11;
					dufp_pkg::LBL_DMX_U0:   cmd.mask = 2'b01;
					default:                cmd.mask = 2'b10;
				endcase
			end
			dufp_pkg::ST_END: begin
				cmd_push = acc && (rx_byte == dufp_pkg::BYTE_EOF);
				case (label_q) inside
					dufp_pkg::LBL_PARAMS: begin
						cmd.op   = dufp_pkg::CMD_REPLY;
						cmd.rsel = dufp_pkg::RPL_PARAMS;
					end
					dufp_pkg::LBL_SERIAL, dufp_pkg::LBL_SERIAL_B, dufp_pkg::LBL_SERIAL_C: begin
						cmd.op   = dufp_pkg::CMD_REPLY;
						cmd.rsel = dufp_pkg::RPL_SERIAL;
					end
					dufp_pkg::LBL_VENDOR: begin
						cmd.op   = dufp_pkg::CMD_REPLY;
						cmd.rsel = dufp_pkg::RPL_VENDOR;
					end
					dufp_pkg::LBL_NAME: begin
						cmd.op   = dufp_pkg::CMD_REPLY;
						cmd.rsel = dufp_pkg::RPL_NAME;
					end
					default: cmd.op = dufp_pkg::CMD_LED;
				endcase
			end
			default: cmd_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dufp_pkg::ST_IDLE;
			label_q <= '0;
			len_q   <= '0;
			woff_q  <= '0;
			scp_q   <= 1'b0;
		end else if (acc) begin
			state_q <= state_next;
			case (state_q)
				dufp_pkg::ST_LABEL: label_q <= rx_byte;
				dufp_pkg::ST_LEN_LO: begin
					len_q  <= dufp_pkg::LEN_W'(rx_byte);
					woff_q <= '0;
				end
				dufp_pkg::ST_LEN_HI: begin
					woff_q <= '0;
					if (full_len == 16'd0) begin
						len_q <= '0;
						scp_q <= 1'b0;
					end else begin
						len_q <= len_d;
						scp_q <= is_data;
					end
				end
				dufp_pkg::ST_DATA: begin
					scp_q  <= 1'b0;
					woff_q <= woff_n;
				end
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/dufp_cmd_queue.sv */
module dufp_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dufp_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output dufp_pkg::cmd_t head_cmd
);

	dufp_pkg::cmd_t                slot_q [dufp_pkg::QDEPTH];
	logic [dufp_pkg::QPTR_W-1:0]   wptr_q, rptr_q;
	logic [dufp_pkg::QCNT_W-1:0]   count_q;
	logic                          do_push, do_pop;

	assign full       = (count_q == dufp_pkg::QCNT_W'(dufp_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + dufp_pkg::QPTR_W'(1);
			if (do_pop)  rptr_q <= rptr_q + dufp_pkg::QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + dufp_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - dufp_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/dufp_back.sv */
module dufp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [39:0]                 param_bytes,
	input  logic [63:0]                 serial_bytes,
	input  logic                        head_valid,
	input  dufp_pkg::cmd_t              head_cmd,
	output logic                        head_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  kind,
	output logic [7:0]                  out_byte,
	output logic [1:0]                  universe_mask,
	output logic [dufp_pkg::CHAN_W-1:0] channel,
	output logic                        last
);

	logic                        out_valid_q;
	logic [1:0]                  kind_q, mask_q;
	logic [7:0]                  byte_q;
	logic [dufp_pkg::CHAN_W-1:0] chan_q;
	logic                        last_q;
	logic [dufp_pkg::RIDX_W-1:0] idx_q;

	logic                        load, head_done;
	logic [1:0]                  r_kind, r_mask;
	logic [7:0]                  r_byte;
	logic [dufp_pkg::CHAN_W-1:0] r_chan;
	logic [7:0]                  rpl_label, rpl_len, rpl_pay;
	logic [3:0]                  pay_idx;
	logic [63:0]                 params_sh, serial_sh;

	assign load     = head_valid && (!out_valid_q || pop);
	assign head_pop = load && head_done;
	assign pay_idx  = 4'(idx_q - dufp_pkg::RIDX_W'(6));
	assign params_sh = {24'd0, param_bytes} >> {pay_idx[2:0], 3'b000};
	assign serial_sh = serial_bytes >> {pay_idx[2:0], 3'b000};

	always_comb begin
		case (head_cmd.rsel)
			dufp_pkg::RPL_PARAMS: begin
				rpl_label = dufp_pkg::LBL_PARAMS;
				rpl_len   = 8'd5;
				rpl_pay   = params_sh[7:0];
			end
			dufp_pkg::RPL_SERIAL: begin
				rpl_label = dufp_pkg::LBL_SERIAL;
				rpl_len   = 8'd8;
				rpl_pay   = serial_sh[7:0];
			end
			dufp_pkg::RPL_VENDOR: begin
				rpl_label = dufp_pkg::LBL_VENDOR;
				rpl_len   = 8'd9;
				rpl_pay   = dufp_pkg::vendor_byte(pay_idx);
			end
			default: begin
				rpl_label = dufp_pkg::LBL_NAME;
				rpl_len   = 8'd15;
				rpl_pay   = dufp_pkg::name_byte(pay_idx);
			end
		endcase
	end

	always_comb begin
		r_kind    = dufp_pkg::KIND_LED;
		r_byte    = 8'h00;
		r_mask    = 2'b00;
		r_chan    = '0;
		head_done = 1'b1;
		case (head_cmd.op)
			dufp_pkg::CMD_WRITE: begin
				r_kind = dufp_pkg::KIND_WRITE;
				r_byte = head_cmd.data;
				r_mask = head_cmd.mask;
				r_chan = head_cmd.chan;
			end
			dufp_pkg::CMD_REPLY: begin
				r_kind    = dufp_pkg::KIND_REPLY;
				head_done = (8'(idx_q) == rpl_len + 8'd6);
				case (idx_q)
					5'd0:    r_byte = dufp_pkg::BYTE_HDR0;
					5'd1:    r_byte = dufp_pkg::BYTE_HDR1;
					5'd2:    r_byte = dufp_pkg::BYTE_SOF;
					5'd3:    r_byte = rpl_label;
					5'd4:    r_byte = rpl_len;
					5'd5:    r_byte = 8'h00;
					default: r_byte = head_done ? dufp_pkg::BYTE_EOF : rpl_pay;
				endcase
			end
			default: r_kind = dufp_pkg::KIND_LED;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= r_kind;
			byte_q <= r_byte;
			mask_q <= r_mask;
			chan_q <= r_chan;
			last_q <= head_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			if (load) idx_q <= head_done ? '0 : (idx_q + dufp_pkg::RIDX_W'(1));
		end
	end

	assign empty         = !out_valid_q;
	assign kind          = kind_q;
	assign out_byte      = byte_q;
	assign universe_mask = mask_q;
	assign channel       = chan_q;
	assign last          = last_q;

endmodule

/* rtl/core/dmx_usb_frame_parser_core.sv */
// Frame parser for a USB DMX interface. Received bytes are pushed in one per
// cycle while full is low and parsed as 0x7E, label, 16-bit little-endian
// length, payload, 0xE7. Data frames (labels 6, 100 and 101) drop their start
// code and turn the next bytes, up to 512, into channel writes for universe 0,
// universe 1 or both. The closing 0xE7 of a request frame produces a reply
// burst of 12 to 22 items (link header 01 60, then the reply frame); any other
// label produces one LED toggle item. A four-entry command queue sits between
// the parser and the result generator, which sends one result item per cycle
// while results are popped. A byte that causes one result therefore flows at
// one item per cycle when results are popped every cycle; a reply burst holds
// the result side until its last item is out, and input stalls (full high)
// only once the command queue has filled behind it. The last output marks the
// final result item caused by an input byte. The two reply registers are
// written through the configuration channel, which is always ready; writes to
// indexes beyond the two registers are ignored.
module dmx_usb_frame_parser_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     rx_byte,
	output logic                           empty,
	input  logic                           pop,
	output logic [1:0]                     kind,
	output logic [7:0]                     out_byte,
	output logic [1:0]                     universe_mask,
	output logic [dufp_pkg::CHAN_W-1:0]    channel,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dufp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data
);

	logic [39:0] params_q;
	logic [63:0] serial_q;

	logic           in_acc;
	logic           cmd_push;
	dufp_pkg::cmd_t cmd;
	logic           head_valid, head_pop;
	dufp_pkg::cmd_t head_cmd;

	// Users write configuration registers only while idle (unenforced).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			params_q <= dufp_pkg::PARAMS_RESET;
			serial_q <= dufp_pkg::SERIAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dufp_pkg::REG_PARAMS: params_q <= cfg_data[39:0];
				dufp_pkg::REG_SERIAL: serial_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Every accepted byte advances the parser, whether or not it causes a result.
	assign in_acc = push && !full;

	dufp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (in_acc),
		.rx_byte  (rx_byte),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	dufp_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_cmd   (cmd),
		.full       (full),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	dufp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.param_bytes   (params_q),
		.serial_bytes  (serial_q),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.head_pop      (head_pop),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.out_byte      (out_byte),
		.universe_mask (universe_mask),
		.channel       (channel),
		.last          (last)
	);

endmodule

/* sim/dmx_usb_frame_parser_core_test.sv */
`timescale 1ns / 100ps

import dufp_pkg::*;

// One result item as it leaves the block.
typedef struct packed {
	logic [1:0]        kind;
	logic [7:0]        data;
	logic [1:0]        mask;
	logic [CHAN_W-1:0] chan;
	logic              last;
} parser_result_t;

// Tracks the frame parser state byte by byte and keeps the result items that
// the block owes, oldest first.
class usb_dmx_predictor;
	localparam logic [1:0] NO_UNI   = 2'b00;
	localparam logic [1:0] UNI_0    = 2'b01;
	localparam logic [1:0] UNI_1    = 2'b10;
	localparam logic [1:0] UNI_BOTH = 2'b11;

	parser_result_t expected_q[$];
	int mismatches;

	logic [39:0]  params;
	logic [63:0]  serial;
	parse_state_t state;
	logic [7:0]   label;
	logic [15:0]  data_count;
	logic [9:0]   offset;
	logic         skip_start;

	logic [7:0] vendor_txt[9];
	logic [7:0] name_txt[15];
	logic [7:0] reply_buf[15];

	function new();
		mismatches = 0;
		params     = PARAMS_RESET;
		serial     = SERIAL_RESET;
		state      = ST_IDLE;
		label      = 8'h00;
		data_count = 16'h0000;
		offset     = 10'h000;
		skip_start = 1'b0;
		vendor_txt = '{8'h6B, 8'h6A, 8'h44, 8'h4D, 8'h58, 8'h4C, 8'h49, 8'h46, 8'h45};
		name_txt   = '{8'h02, 8'h00, 8'h44, 8'h4D, 8'h58, 8'h20, 8'h55, 8'h6C,
			8'h74, 8'h72, 8'h61, 8'h20, 8'h50, 8'h72, 8'h6F};
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
		case (idx)
			REG_PARAMS: params = d[39:0];
			REG_SERIAL: serial = d;
			default: ;
		endcase
	endfunction

	function int outstanding();
		return expected_q.size();
	endfunction

	function bit is_data(logic [7:0] lbl);
		return lbl == LBL_DMX_BOTH || lbl == LBL_DMX_U0 || lbl == LBL_DMX_U1;
	endfunction

	function logic [1:0] mask_of(logic [7:0] lbl);
		case (lbl)
			LBL_DMX_BOTH: return UNI_BOTH;
			LBL_DMX_U0:   return UNI_0;
			default:      return UNI_1;
		endcase
	endfunction

	function void emit(logic [1:0] k, logic [7:0] d, logic [1:0] m, logic [CHAN_W-1:0] c);
		parser_result_t r;
		r.kind = k;
		r.data = d;
		r.mask = m;
		r.chan = c;
		r.last = 1'b0;
		expected_q.push_back(r);
	endfunction

	// Link header, then a complete frame around the first n bytes of reply_buf.
	function void emit_reply(logic [7:0] lbl, int n);
		logic [15:0] len16;
		len16 = n[15:0];
		emit(KIND_REPLY, BYTE_HDR0, NO_UNI, '0);
		emit(KIND_REPLY, BYTE_HDR1, NO_UNI, '0);
		emit(KIND_REPLY, BYTE_SOF, NO_UNI, '0);
		emit(KIND_REPLY, lbl, NO_UNI, '0);
		emit(KIND_REPLY, len16[7:0], NO_UNI, '0);
		emit(KIND_REPLY, len16[15:8], NO_UNI, '0);
		for (int i = 0; i < n; i++)
			emit(KIND_REPLY, reply_buf[i], NO_UNI, '0);
		emit(KIND_REPLY, BYTE_EOF, NO_UNI, '0);
	endfunction

	function void frame_closed();
		case (label)
			LBL_PARAMS: begin
				for (int i = 0; i < 5; i++)
					reply_buf[i] = params[8*i +: 8];
				emit_reply(LBL_PARAMS, 5);
			end
			LBL_SERIAL, LBL_SERIAL_B, LBL_SERIAL_C: begin
				for (int i = 0; i < 8; i++)
					reply_buf[i] = serial[8*i +: 8];
				emit_reply(LBL_SERIAL, 8);
			end
			LBL_VENDOR: begin
				for (int i = 0; i < 9; i++)
					reply_buf[i] = vendor_txt[i];
				emit_reply(LBL_VENDOR, 9);
			end
			LBL_NAME: begin
				for (int i = 0; i < 15; i++)
					reply_buf[i] = name_txt[i];
				emit_reply(LBL_NAME, 15);
			end
			default: emit(KIND_LED, 8'h00, NO_UNI, '0);
		endcase
	endfunction

	// Advances the parser by one accepted byte and queues what it causes.
	function void take_byte(logic [7:0] b);
		int             n_prior;
		logic [31:0]    flen;
		parser_result_t tail;
		n_prior = expected_q.size();
		case (state)
			ST_LABEL: begin
				label = b;
				state = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				data_count = {8'h00, b};
				offset     = '0;
				state      = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				flen   = {16'h0000, b, data_count[7:0]};
				offset = '0;
				if (flen == 0) begin
					data_count = '0;
					skip_start = 1'b0;
					state      = ST_END;
				end else begin
					skip_start = is_data(label);
					if (skip_start)
						flen = flen - 1;
					if (flen > MAX_CHANNELS)
						flen = MAX_CHANNELS;
					data_count = flen[15:0];
					state      = ST_DATA;
				end
			end
			ST_DATA: begin
				if (skip_start) begin
					skip_start = 1'b0;
				end else begin
					if (is_data(label))
						emit(KIND_WRITE, b, mask_of(label), offset[CHAN_W-1:0]);
					offset = offset + 10'd1;
				end
				if ({6'h00, offset} >= data_count)
					state = ST_END;
			end
			ST_END: begin
				if (b == BYTE_EOF) begin
					frame_closed();
					state = ST_IDLE;
				end
			end
			default: state = (b == BYTE_SOF) ? ST_LABEL : ST_IDLE;
		endcase
		if (expected_q.size() > n_prior) begin
			tail      = expected_q.pop_back();
			tail.last = 1'b1;
			expected_q.push_back(tail);
		end
	endfunction

	function void check_item(logic [1:0] k, logic [7:0] d, logic [1:0] m,
			logic [CHAN_W-1:0] c, logic l);
		parser_result_t want;
		if (expected_q.size() == 0) begin
			$error("result with nothing expected: kind %0d out_byte %02h", k, d);
			mismatches++;
			return;
		end
		want = expected_q.pop_front();
		if (k !== want.kind) begin
			$error("kind: expected %0d, got %0d", want.kind, k);
			mismatches++;
		end
		if (d !== want.data) begin
			$error("out_byte: expected %02h, got %02h", want.data, d);
			mismatches++;
		end
		if (m !== want.mask) begin
			$error("universe_mask: expected %0d, got %0d", want.mask, m);
			mismatches++;
		end
		if (c !== want.chan) begin
			$error("channel: expected %0d, got %0d", want.chan, c);
			mismatches++;
		end
		if (l !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, l);
			mismatches++;
		end
	endfunction
endclass

module dmx_usb_frame_parser_core_test;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 10;
	localparam int MAX_GAP        = 17;
	// Cycles allowed after the last expected item before a register write or
	// the final verdict. Bytes that cause nothing leave no work behind, so a
	// short settle covers the command queue and the result stage.
	localparam int SETTLE_CYCLES  = 12;
	// Cycles with no handshake of any kind before the run is declared hung.
	// The longest legal quiet stretch is a full idle gap on one side or a
	// settle period, both far below this.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_BYTES    = 105;

	// Register indexes past the two real registers; the block drops these.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 push          = 1'b0;
	logic                 full;
	logic [7:0]           rx_byte       = 8'h00;
	logic                 empty;
	logic                 pop           = 1'b0;
	logic [1:0]           kind;
	logic [7:0]           out_byte;
	logic [1:0]           universe_mask;
	logic [CHAN_W-1:0]    channel;
	logic                 last;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [63:0]          cfg_data      = '0;

	dmx_usb_frame_parser_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.rx_byte       (rx_byte),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.out_byte      (out_byte),
		.universe_mask (universe_mask),
		.channel       (channel),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	usb_dmx_predictor frame_model = new();

	// Number of input bytes accepted so far; the random traffic budget
	// is counted against it.
	int bytes_sent = 0;

	// Each side runs in stretches: either every item waits a random idle gap
	// bounded by MAX_GAP, or the side runs flat out. Stretch length is random
	// too, so the gaps land on every phase of a frame and of a reply burst.
	int tx_left = 0;
	int rx_left = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	function automatic int draw_gap(inout int left, inout bit calm);
		if (left == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			left = $urandom_range(10, 40);
		end
		left--;
		return calm ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Offers one byte and holds it until the block takes it. Push stays high
	// between back-to-back items, so it is never lowered and raised at the
	// same edge.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = draw_gap(tx_left, tx_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		frame_model.take_byte(b);
		bytes_sent++;
	endtask

	// Start byte, label, little-endian length, then n_pay random payload bytes
	// and n_extra random trailing bytes. The end byte is optional so that
	// broken frames can be made with the same task.
	task automatic send_frame(input logic [7:0] lbl, input logic [15:0] len,
			input int n_pay, input int n_extra, input bit close);
		send_byte(BYTE_SOF);
		send_byte(lbl);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		repeat (n_pay) send_byte(8'($urandom_range(0, 255)));
		repeat (n_extra) send_byte(8'($urandom_range(0, 255)));
		if (close)
			send_byte(BYTE_EOF);
	endtask

	// Stops the sender and waits for every owed item to come out, then lets
	// the pipeline settle so that a register write cannot overtake work.
	task automatic await_quiet();
		push <= 1'b0;
		while (frame_model.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Valid is held across consecutive writes and dropped by the caller.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		frame_model.write_reg(idx, d);
	endtask

	// Both real registers plus both spare indexes, which must change nothing.
	task automatic set_registers(input logic [63:0] p, input logic [63:0] s);
		write_reg(REG_PARAMS, p);
		write_reg(REG_SPARE_LO, {$urandom, $urandom});
		write_reg(REG_SPARE_HI, {$urandom, $urandom});
		write_reg(REG_SERIAL, s);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_label();
		case ($urandom_range(0, 11))
			0:       return LBL_PARAMS;
			1:       return LBL_DMX_BOTH;
			2:       return LBL_SERIAL;
			3:       return LBL_SERIAL_B;
			4:       return LBL_VENDOR;
			5:       return LBL_NAME;
			6:       return LBL_DMX_U0;
			7:       return LBL_DMX_U1;
			8:       return LBL_SERIAL_C;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly well-formed frames with random labels and short random payloads,
	// since only those reach the data and reply paths. The rest is loose
	// noise between frames and frames cut short or left without an end byte.
	task automatic random_traffic(input int budget);
		int          stop_at;
		int          pick;
		logic [15:0] len;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 9);
			len  = 16'($urandom_range(0, 10));
			if (pick == 0) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end else if (pick == 1) begin
				send_frame(pick_label(), len, $urandom_range(0, len + 2), 0,
					1'($urandom_range(0, 1)));
			end else begin
				send_frame(pick_label(), len, len,
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 1'b1);
			end
		end
	endtask

	// Nothing is accepted for too long: the block or the handshake has hung.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: takes items with random stalls and checks each one against
	// the oldest owed item. It runs for the whole test, so anything the block
	// emits late or unasked is still caught.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(rx_left, rx_calm);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			frame_model.check_item(kind, out_byte, universe_mask, channel, last);
		end
	end

	initial begin
		logic [63:0] p_val;
		logic [63:0] s_val;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, with the registers at their reset values.
		// Stray bytes outside any frame, an end byte among them, are ignored.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(BYTE_EOF);
		// Label 6 writes both universes: the start code is dropped, then
		// channels 0 and 1 get the extreme values; the label is not a
		// request, so the end byte gives an LED toggle.
		send_byte(BYTE_SOF);
		send_byte(LBL_DMX_BOTH);
		send_byte(8'h03);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(BYTE_EOF);
		// A zero-length serial request under its alias label goes straight
		// to the end byte and answers with the serial reply.
		send_frame(LBL_SERIAL_B, 16'd0, 0, 0, 1'b1);
		// A data frame of length one holds only its start code: no writes.
		send_frame(LBL_DMX_U1, 16'd1, 1, 0, 1'b1);

		// Each phase drains, reprograms both registers and runs random
		// traffic. The drain also covers the required sender pause.
		for (int phase = 0; phase < 4; phase++) begin
			await_quiet();
			case (phase)
				0: begin
					p_val = '0;
					s_val = '1;
				end
				1: begin
					p_val = '1;
					s_val = '0;
				end
				default: begin
					p_val = {$urandom, $urandom};
					s_val = {$urandom, $urandom};
				end
			endcase
			set_registers(p_val, s_val);
			random_traffic(PHASE_BYTES);
		end

		await_quiet();
		if (frame_model.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
